[rtl/acps_pkg.sv]
// Shared constants, types and state codes of the ambient cube probe grid sampler.
`default_nettype none
package acps_pkg;
  localparam int unsigned GRID_X_DEF  = 8;
  localparam int unsigned GRID_Y_DEF  = 8;
  localparam int unsigned GRID_Z_DEF  = 8;
  localparam int unsigned LOBES       = 6;
  localparam int unsigned CHANNELS    = 3;
  localparam int unsigned PROBE_WORDS = LOBES * CHANNELS;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned NUM_W       = 48;
  localparam int unsigned DEN_W       = 32;
  localparam int unsigned VAL_W       = 36;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned WGT_W       = 17;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] CFG_SPACING_X = 3'd3;
  localparam logic [2:0] CFG_SPACING_Y = 3'd4;
  localparam logic [2:0] CFG_SPACING_Z = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CRD, ST_CRD_WAIT, ST_SQ, ST_WGT, ST_WGT_WAIT, ST_ADR1, ST_ADR2,
    ST_RD, ST_MAC, ST_DLV, ST_LRP1, ST_LRP2, ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/acps_ram.sv]
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module acps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/acps_div.sv]
// Restoring serial divider that produces one quotient bit per cycle.
`default_nettype none
module acps_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire acps_pkg::div_req_t req_i,
  output acps_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned NW = acps_pkg::NUM_W;
  localparam int unsigned DW = acps_pkg::DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   sh_c;
  logic [DW+1:0] diff_c;

  assign sh_c   = {rem_q, quo_q[NW-1]};
  assign diff_c = {1'b0, sh_c} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (!diff_c[DW+1]) begin
        rem_q <= diff_c[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= sh_c[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

[rtl/ambient_cube_probe_grid_sampler.sv]
// Top level of the ambient cube probe grid sampler.
//
// Channel  Direction  Signals
// in       input      in_valid_i/in_ready_o, action_i, word_index_i, word_value_i,
//                     pos_x_i..pos_z_i, normal_x_i..normal_z_i
// out      output     out_valid_o/out_ready_i, red_o, green_o, blue_o
// cfg      input      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// A sample takes up to nine divisions on the one serial divider and 144 reads
// through the single RAM read port, each followed by a multiply-accumulate,
// plus the lerp steps.
// Reset clears the control state; the probe store is undefined until written.
// A finished result waits in the output register while write words go on.
`default_nettype none
module ambient_cube_probe_grid_sampler #(
  parameter int unsigned GRID_X = acps_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = acps_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = acps_pkg::GRID_Z_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic [13:0]        word_index_i,
  input  wire logic [15:0]        word_value_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] normal_x_i,
  input  wire logic signed [15:0] normal_y_i,
  input  wire logic signed [15:0] normal_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             red_o,
  output logic [15:0]             green_o,
  output logic [15:0]             blue_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam int unsigned DEPTH = GRID_X * GRID_Y * GRID_Z * acps_pkg::PROBE_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = acps_pkg::IDX_W;
  localparam int unsigned LW    = IW + 16;
  localparam int unsigned NW    = acps_pkg::NUM_W;
  localparam int unsigned VW    = acps_pkg::VAL_W;
  localparam int unsigned WW    = acps_pkg::WGT_W;
  localparam int unsigned MW    = VW + WW;
  localparam logic [IW-1:0] XM1 = IW'(GRID_X - 1);
  localparam logic [IW-1:0] YM1 = IW'(GRID_Y - 1);
  localparam logic [IW-1:0] ZM1 = IW'(GRID_Z - 1);

  acps_pkg::state_e   state_q, state_d;
  acps_pkg::div_req_t div_req;
  acps_pkg::div_rsp_t div_rsp;

  logic signed [31:0] org_q [3];
  logic [31:0]        sp_q [3];
  logic [31:0]        pos_q [3];
  logic signed [15:0] nrm_q [3];
  logic [2:0]         k_q, corner_q, lobe_q;
  logic [1:0]         ch_q, lvl_q;
  logic [IW-1:0]      lo_q [3];
  logic [IW-1:0]      hi_q [3];
  logic [15:0]        t_q [3];
  logic [30:0]        sq_q [6];
  logic [31:0]        sum_q;
  logic [WW-1:0]      w_q [6];
  logic [AW-1:0]      prow_q, raddr_q;
  logic [VW-1:0]      acc_q, bv_q;
  logic [VW-1:0]      slot_q [3];
  logic [MW-1:0]      lacc_q;
  logic [15:0]        res_q [3];
  logic               out_valid_q;
  logic [15:0]        red_q, green_q, blue_q;

  logic               in_acc, ram_we, ram_re, dpos_c, wskip_c, out_free;
  logic [1:0]         ax;
  logic [32:0]        d_c;
  logic [31:0]        sp_eff_c, widx_c;
  logic [IW-1:0]      dm1_c, cx, cy, cz, lo_c;
  logic [LW-1:0]      lim_c, coord_c;
  logic signed [31:0] sqr_c;
  logic [15:0]        rdata;
  logic [32:0]        prod_c;
  logic [VW-1:0]      acc_n, mul_a, lres_c;
  logic [WW-1:0]      mul_b;
  logic [MW-1:0]      mul_c;
  logic [MW:0]        lsum_c;
  logic [VW:0]        rnd_c;
  logic [15:0]        sat_c;

  assign ax       = k_q[1:0];
  assign d_c      = {pos_q[ax][31], pos_q[ax]} - {org_q[ax][31], org_q[ax]};
  assign dpos_c   = !d_c[32] && (d_c != '0);
  assign sp_eff_c = (sp_q[ax] == '0) ? acps_pkg::ONE_Q16 : sp_q[ax];
  assign wskip_c  = (sum_q == '0) || (sq_q[k_q] == '0);
  assign widx_c   = 32'(word_index_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (ax)
      2'd0:    dm1_c = XM1;
      2'd1:    dm1_c = YM1;
      default: dm1_c = ZM1;
    endcase
  end

  assign lim_c = {dm1_c, 16'h0000};
  always_comb begin
    if (state_q != acps_pkg::ST_CRD_WAIT) begin
      coord_c = '0;
    end else if (div_rsp.quo > NW'(lim_c)) begin
      coord_c = lim_c;
    end else begin
      coord_c = div_rsp.quo[LW-1:0];
    end
  end
  assign lo_c  = coord_c[LW-1:16];
  assign sqr_c = nrm_q[ax] * nrm_q[ax];

  assign cx = corner_q[0] ? hi_q[0] : lo_q[0];
  assign cy = corner_q[1] ? hi_q[1] : lo_q[1];
  assign cz = corner_q[2] ? hi_q[2] : lo_q[2];

  assign prod_c = rdata * w_q[lobe_q];
  assign acc_n  = acc_q + VW'(prod_c);

  assign mul_a  = (state_q == acps_pkg::ST_LRP1) ? slot_q[lvl_q] : bv_q;
  assign mul_b  = (state_q == acps_pkg::ST_LRP1) ? (WW'(65536) - {1'b0, t_q[lvl_q]})
                                                 : {1'b0, t_q[lvl_q]};
  assign mul_c  = mul_a * mul_b;
  assign lsum_c = {1'b0, lacc_q} + {1'b0, mul_c};
  assign lres_c = lsum_c[16+VW-1:16];
  assign rnd_c  = {1'b0, lres_c} + (VW+1)'(32768);
  assign sat_c  = (rnd_c[VW:32] != '0) ? 16'hFFFF : rnd_c[31:16];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acps_pkg::ST_IDLE: begin
        if (in_valid_i && action_i == acps_pkg::ACT_SAMPLE) state_d = acps_pkg::ST_CRD;
      end
      acps_pkg::ST_CRD: begin
        if (dpos_c) state_d = acps_pkg::ST_CRD_WAIT;
        else if (k_q == 3'd2) state_d = acps_pkg::ST_SQ;
      end
      acps_pkg::ST_CRD_WAIT: begin
        if (div_rsp.done) state_d = (k_q == 3'd2) ? acps_pkg::ST_SQ : acps_pkg::ST_CRD;
      end
      acps_pkg::ST_SQ: begin
        if (k_q == 3'd2) state_d = acps_pkg::ST_WGT;
      end
      acps_pkg::ST_WGT: begin
        if (!wskip_c) state_d = acps_pkg::ST_WGT_WAIT;
        else if (k_q == 3'd5) state_d = acps_pkg::ST_ADR1;
      end
      acps_pkg::ST_WGT_WAIT: begin
        if (div_rsp.done) state_d = (k_q == 3'd5) ? acps_pkg::ST_ADR1 : acps_pkg::ST_WGT;
      end
      acps_pkg::ST_ADR1: state_d = acps_pkg::ST_ADR2;
      acps_pkg::ST_ADR2: state_d = acps_pkg::ST_RD;
      acps_pkg::ST_RD:   state_d = acps_pkg::ST_MAC;
      acps_pkg::ST_MAC: begin
        state_d = (lobe_q == 3'd5) ? acps_pkg::ST_DLV : acps_pkg::ST_RD;
      end
      acps_pkg::ST_DLV: begin
        state_d = corner_q[lvl_q] ? acps_pkg::ST_LRP1 : acps_pkg::ST_ADR1;
      end
      acps_pkg::ST_LRP1: state_d = acps_pkg::ST_LRP2;
      acps_pkg::ST_LRP2: begin
        if (lvl_q != 2'd2) state_d = acps_pkg::ST_DLV;
        else state_d = (ch_q == 2'd2) ? acps_pkg::ST_FIN : acps_pkg::ST_ADR1;
      end
      acps_pkg::ST_FIN: begin
        if (out_free) state_d = acps_pkg::ST_IDLE;
      end
      default: state_d = acps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == acps_pkg::ST_IDLE);
    in_acc        = in_valid_i && in_ready_o;
    ram_we        = in_acc && (action_i == acps_pkg::ACT_WRITE) && (widx_c < 32'(DEPTH));
    ram_re        = (state_q == acps_pkg::ST_RD);
    div_req.start = ((state_q == acps_pkg::ST_CRD) && dpos_c) ||
                    ((state_q == acps_pkg::ST_WGT) && !wskip_c);
    if (state_q == acps_pkg::ST_CRD) begin
      div_req.num = {d_c[31:0], 16'h0000};
      div_req.den = sp_eff_c;
    end else begin
      div_req.num = {1'b0, sq_q[k_q], 16'h0000};
      div_req.den = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acps_pkg::ST_IDLE;
      org_q[0]    <= '0;
      org_q[1]    <= '0;
      org_q[2]    <= '0;
      sp_q[0]     <= acps_pkg::ONE_Q16;
      sp_q[1]     <= acps_pkg::ONE_Q16;
      sp_q[2]     <= acps_pkg::ONE_Q16;
      k_q         <= '0;
      corner_q    <= '0;
      lobe_q      <= '0;
      ch_q        <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          acps_pkg::CFG_ORIGIN_X:  org_q[0] <= cfg_data_i;
          acps_pkg::CFG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
          acps_pkg::CFG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
          acps_pkg::CFG_SPACING_X: sp_q[0]  <= cfg_data_i;
          acps_pkg::CFG_SPACING_Y: sp_q[1]  <= cfg_data_i;
          acps_pkg::CFG_SPACING_Z: sp_q[2]  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        acps_pkg::ST_IDLE: begin
          k_q <= '0;
        end
        acps_pkg::ST_CRD: begin
          if (!dpos_c) k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
        end
        acps_pkg::ST_CRD_WAIT: begin
          if (div_rsp.done) k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
        end
        acps_pkg::ST_SQ: begin
          k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
        end
        acps_pkg::ST_WGT, acps_pkg::ST_WGT_WAIT: begin
          if ((state_q == acps_pkg::ST_WGT && wskip_c) || div_rsp.done) begin
            k_q      <= k_q + 3'd1;
            corner_q <= '0;
            ch_q     <= '0;
          end
        end
        acps_pkg::ST_ADR2: lobe_q <= '0;
        acps_pkg::ST_MAC: begin
          lobe_q <= lobe_q + 3'd1;
          lvl_q  <= '0;
        end
        acps_pkg::ST_DLV: begin
          if (!corner_q[lvl_q]) corner_q <= corner_q + 3'd1;
        end
        acps_pkg::ST_LRP2: begin
          if (lvl_q == 2'd2) begin
            corner_q <= corner_q + 3'd1;
            ch_q     <= ch_q + 2'd1;
          end else begin
            lvl_q <= lvl_q + 2'd1;
          end
        end
        acps_pkg::ST_FIN: begin
          if (out_free) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      acps_pkg::ST_IDLE: begin
        if (in_acc) begin
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          nrm_q[0] <= normal_x_i;
          nrm_q[1] <= normal_y_i;
          nrm_q[2] <= normal_z_i;
          sum_q    <= '0;
        end
      end
      acps_pkg::ST_CRD, acps_pkg::ST_CRD_WAIT: begin
        if ((state_q == acps_pkg::ST_CRD && !dpos_c) || div_rsp.done) begin
          lo_q[ax] <= lo_c;
          t_q[ax]  <= coord_c[15:0];
          hi_q[ax] <= (lo_c == dm1_c) ? lo_c : lo_c + 1'b1;
        end
      end
      acps_pkg::ST_SQ: begin
        sq_q[{ax, 1'b0}] <= (nrm_q[ax] > 0) ? sqr_c[30:0] : '0;
        sq_q[{ax, 1'b1}] <= (nrm_q[ax] < 0) ? sqr_c[30:0] : '0;
        sum_q            <= sum_q + {1'b0, sqr_c[30:0]};
      end
      acps_pkg::ST_WGT: begin
        if (wskip_c) begin
          w_q[k_q] <= (sum_q == '0 && k_q == 3'd2) ? WW'(65536) : '0;
        end
      end
      acps_pkg::ST_WGT_WAIT: begin
        if (div_rsp.done) w_q[k_q] <= div_rsp.quo[WW-1:0];
      end
      acps_pkg::ST_ADR1: begin
        prow_q <= AW'(32'(cz) * GRID_Y + 32'(cy));
      end
      acps_pkg::ST_ADR2: begin
        raddr_q <= AW'((32'(prow_q) * GRID_X + 32'(cx)) * acps_pkg::PROBE_WORDS +
                       32'(ch_q));
        acc_q   <= '0;
      end
      acps_pkg::ST_MAC: begin
        acc_q   <= acc_n;
        raddr_q <= raddr_q + AW'(acps_pkg::CHANNELS);
        bv_q    <= acc_n;
      end
      acps_pkg::ST_DLV: begin
        if (!corner_q[lvl_q]) slot_q[lvl_q] <= bv_q;
      end
      acps_pkg::ST_LRP1: lacc_q <= mul_c;
      acps_pkg::ST_LRP2: begin
        if (lvl_q == 2'd2) res_q[ch_q] <= sat_c;
        else bv_q <= lres_c;
      end
      acps_pkg::ST_FIN: begin
        if (out_free) begin
          red_q   <= res_q[0];
          green_q <= res_q[1];
          blue_q  <= res_q[2];
        end
      end
      default: ;
    endcase
  end

  acps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  acps_ram #(
    .WIDTH (acps_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_c[AW-1:0]),
    .wdata_i (word_value_i),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
endmodule
`default_nettype wire

[rtl/acps_chk.sv]
// Port-level checker for the ambient cube probe grid sampler, with its bind.
`default_nettype none
module acps_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        action_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] red_o,
  input wire logic [15:0] green_o,
  input wire logic [15:0] blue_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("Result word changed while stalled.");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == acps_pkg::ACT_WRITE && !out_valid_o
    |=> !out_valid_o)
    else $error("A write word produced a result.");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == acps_pkg::ACT_SAMPLE |=> !in_ready_o)
    else $error("Input taken while a sample is in progress.");
endmodule

bind ambient_cube_probe_grid_sampler acps_chk u_acps_chk (.*);
`default_nettype wire

[tb/sv/ambient_cube_probe_grid_sampler_test.sv]
// Self-checking testbench of the ambient cube probe grid sampler with a scoreboard predictor.
`timescale 1ns / 100ps
module ambient_cube_probe_grid_sampler_test;
  import acps_pkg::*;

  localparam int unsigned DEPTH = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF * PROBE_WORDS;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE = 1000;

  typedef struct {
    logic               action;
    logic [13:0]        index;
    logic [15:0]        value;
    logic signed [31:0] pos [3];
    logic signed [15:0] nrm [3];
  } probe_item_t;

  typedef struct {
    logic [15:0] rgb [3];
  } irradiance_t;

  class irradiance_scoreboard;
    logic [15:0]        store [DEPTH];
    logic signed [31:0] origin [3];
    logic [31:0]        spacing [3];
    irradiance_t        pending [$];
    int unsigned        errors;
    int unsigned        samples;
    int unsigned        writes;

    function new();
      for (int k = 0; k < 3; k++) begin
        origin[k] = '0;
        spacing[k] = ONE_Q16;
      end
      errors = 0;
      samples = 0;
      writes = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      if (idx < CFG_SPACING_X) origin[idx] = data;
      else spacing[idx - CFG_SPACING_X] = data;
    endfunction

    function automatic logic [63:0] axis_coord(logic signed [31:0] p, logic signed [31:0] o,
                                               logic [31:0] sp, int unsigned dim);
      longint d;
      logic [63:0] g;
      logic [63:0] lim;
      d = longint'(p) - longint'(o);
      lim = 64'(dim - 1) << 16;
      if (sp == 0) sp = ONE_Q16;
      if (d <= 0) return 64'd0;
      g = (64'(d) << 16) / 64'(sp);
      return (g > lim) ? lim : g;
    endfunction

    function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [31:0] t);
      return (a * (64'd65536 - t) + b * 64'(t)) >> 16;
    endfunction

    function automatic logic [63:0] probe_sum(int unsigned x, int unsigned y, int unsigned z,
                                              int unsigned ch, logic [31:0] w [6]);
      int unsigned base;
      logic [63:0] acc;
      base = ((z * GRID_Y_DEF + y) * GRID_X_DEF + x) * PROBE_WORDS;
      acc = 0;
      for (int i = 0; i < LOBES; i++)
        acc += 64'(store[base + i * CHANNELS + ch]) * 64'(w[i]);
      return acc;
    endfunction

    function void note_input(probe_item_t it);
      int unsigned dims [3];
      int unsigned lo [3];
      int unsigned hi [3];
      logic [31:0] t [3];
      logic [63:0] sq [6];
      logic [63:0] total;
      logic [31:0] w [6];
      logic [63:0] c;
      logic [63:0] c00, c10, c01, c11, c0, c1, v;
      longint n;
      irradiance_t res;
      if (it.action == ACT_WRITE) begin
        writes++;
        if (it.index < DEPTH) store[it.index] = it.value;
        return;
      end
      samples++;
      dims = '{GRID_X_DEF, GRID_Y_DEF, GRID_Z_DEF};
      for (int k = 0; k < 3; k++) begin
        c = axis_coord(it.pos[k], origin[k], spacing[k], dims[k]);
        lo[k] = c >> 16;
        t[k] = c & 64'hFFFF;
        hi[k] = (lo[k] + 1 < dims[k]) ? lo[k] + 1 : lo[k];
      end
      total = 0;
      for (int k = 0; k < 3; k++) begin
        n = it.nrm[k];
        sq[2 * k] = (n > 0) ? 64'(n * n) : 64'd0;
        sq[2 * k + 1] = (n < 0) ? 64'(n * n) : 64'd0;
        total += 64'(n * n);
      end
      for (int k = 0; k < 6; k++)
        w[k] = (total != 0) ? 32'((sq[k] << 16) / total) : ((k == 2) ? ONE_Q16 : 32'd0);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        c00 = lerp(probe_sum(lo[0], lo[1], lo[2], ch, w), probe_sum(hi[0], lo[1], lo[2], ch, w),
                   t[0]);
        c10 = lerp(probe_sum(lo[0], hi[1], lo[2], ch, w), probe_sum(hi[0], hi[1], lo[2], ch, w),
                   t[0]);
        c01 = lerp(probe_sum(lo[0], lo[1], hi[2], ch, w), probe_sum(hi[0], lo[1], hi[2], ch, w),
                   t[0]);
        c11 = lerp(probe_sum(lo[0], hi[1], hi[2], ch, w), probe_sum(hi[0], hi[1], hi[2], ch, w),
                   t[0]);
        c0 = lerp(c00, c10, t[1]);
        c1 = lerp(c01, c11, t[1]);
        v = (lerp(c0, c1, t[2]) + 64'd32768) >> 16;
        res.rgb[ch] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      pending.push_back(res);
    endfunction

    task report(string what, logic [15:0] want, logic [15:0] got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      errors++;
    endtask

    task check_result(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      irradiance_t want;
      if (pending.size() == 0) begin
        report("unexpected word red", 16'd0, r);
        return;
      end
      want = pending.pop_front();
      if (want.rgb[0] !== r) report("red", want.rgb[0], r);
      if (want.rgb[1] !== g) report("green", want.rgb[1], g);
      if (want.rgb[2] !== b) report("blue", want.rgb[2], b);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = ACT_WRITE;
  logic [13:0] word_index_i = '0;
  logic [15:0] word_value_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] red_o, green_o, blue_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = CFG_ORIGIN_X;
  logic [31:0] cfg_data_i = '0;

  irradiance_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;

  ambient_cube_probe_grid_sampler DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .word_index_i, .word_value_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .normal_x_i, .normal_y_i, .normal_z_i,
    .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver is ready on half of its draws and ready one time in four on the rest.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(red_o, green_o, blue_o);
      results_seen++;
    end
    if (($urandom_range(0, 399) < 200) == ((results_seen / 16) % 2 == 0))
      out_ready_i <= 1'b1;
    else
      out_ready_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding", sb.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push(probe_item_t it);
    in_valid_i <= 1'b1;
    action_i <= it.action;
    word_index_i <= it.index;
    word_value_i <= it.value;
    pos_x_i <= it.pos[0];
    pos_y_i <= it.pos[1];
    pos_z_i <= it.pos[2];
    normal_x_i <= it.nrm[0];
    normal_y_i <= it.nrm[1];
    normal_z_i <= it.nrm[2];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic pause(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic apply_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                               logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    drain();
    write_register(CFG_ORIGIN_X, ox);
    write_register(CFG_ORIGIN_Y, oy);
    write_register(CFG_ORIGIN_Z, oz);
    write_register(CFG_SPACING_X, sx);
    write_register(CFG_SPACING_Y, sy);
    write_register(CFG_SPACING_Z, sz);
    settings_used++;
  endtask

  function automatic probe_item_t write_word(int unsigned idx, logic [15:0] val);
    probe_item_t it;
    it.action = ACT_WRITE;
    it.index = idx;
    it.value = val;
    for (int k = 0; k < 3; k++) begin
      it.pos[k] = $urandom;
      it.nrm[k] = $urandom;
    end
    return it;
  endfunction

  function automatic probe_item_t sample_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                           logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    probe_item_t it;
    it.action = ACT_SAMPLE;
    it.index = $urandom;
    it.value = $urandom;
    it.pos = '{px, py, pz};
    it.nrm = '{nx, ny, nz};
    return it;
  endfunction

  function automatic logic [15:0] random_radiance();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_normal_part();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return $urandom;
    endcase
  endfunction

  // Positions mostly land inside or just around the grid for the current setting.
  function automatic logic [31:0] random_position(int k);
    longint sp;
    if ($urandom_range(0, 4) == 0) return $urandom;
    sp = (sb.spacing[k] == 0) ? 65536 : sb.spacing[k];
    return 32'(longint'(sb.origin[k]) +
               (longint'($urandom_range(0, 10000)) - 1000) * sp / 1000);
  endfunction

  function automatic probe_item_t random_item();
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 5) == 0) return write_word($urandom_range(DEPTH, 16383),
                                                       random_radiance());
      return write_word($urandom_range(0, DEPTH - 1), random_radiance());
    end
    if ($urandom_range(0, 7) == 0)
      return sample_at(random_position(0), random_position(1), random_position(2),
                       16'h0, 16'h0, 16'h0);
    return sample_at(random_position(0), random_position(1), random_position(2),
                     random_normal_part(), random_normal_part(), random_normal_part());
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        push(random_item());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every probe word is written before any sample may read it.
    for (int unsigned a = 0; a < DEPTH; a++) push(write_word(a, random_radiance()));
    push(write_word(0, 16'hFFFF));
    push(write_word(DEPTH - 1, 16'hFFFF));
    push(write_word(DEPTH, 16'h1234));
    push(write_word(16383, 16'hFFFF));

    push(sample_at(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0));
    push(sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h0, 16'h0));
    push(sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h0, 16'h0));
    push(sample_at(32'h0007_0000, 32'h0007_0000, 32'h0007_0000, 16'h0, 16'h7FFF, 16'h0));
    push(sample_at(32'h0000_8000, 32'h0001_4000, 32'h0002_C000, 16'h0, 16'h8000, 16'h0));
    push(sample_at(32'h0003_FFFF, 32'h0004_0001, 32'h0006_8000, 16'h0, 16'h0, 16'h7FFF));
    push(sample_at(32'h0006_FFFF, 32'h0000_0001, 32'h0005_1234, 16'h0, 16'h0, 16'h8000));
    push(sample_at(32'h0002_8000, 32'h0003_8000, 32'h0004_8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    push(sample_at(32'hFFFF_0000, 32'h0009_0000, 32'h0001_0000, 16'hFFFF, 16'h0001, 16'hFFFF));
    push(sample_at(32'h0003_2000, 32'h0001_E000, 32'h0006_0000, 16'h0001, 16'h0000, 16'h0000));
    push(sample_at(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 16'hAAAA, 16'h5555, 16'h1234));

    // The sender holds off here until every result has come back.
    drain();
    random_phase(150);

    apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    push(sample_at(32'h8000_0000, 32'h8003_8000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0));
    random_phase(130);
    apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    random_phase(130);
    apply_setting(32'hFFFC_0000, 32'h0002_0000, 32'h0, 32'h0000_4000, 32'h0002_0000,
                  32'h0000_0001);
    random_phase(150);
    apply_setting($urandom, $urandom, $urandom, $urandom_range(1, 32'h0010_0000),
                  $urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000));
    random_phase(150);
    apply_setting(32'hFFFF_8000, 32'h0000_C000, 32'hFFF0_0000, 32'h0001_8000, 32'h0000_8000,
                  32'h0003_0000);
    random_phase(150);
    apply_setting(32'h0, 32'h0, 32'h0, ONE_Q16, ONE_Q16, ONE_Q16);
    random_phase(150);

    drain();
    if (sb.pending.size() != 0) sb.report("words never delivered", 16'd0,
                                          16'(sb.pending.size()));
    $display("Covered %0d sample words and %0d probe writes over %0d register settings.",
             sb.samples, sb.writes, settings_used);
    $display("%0d results checked, %0d mismatches.", results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
